// ===== hdl/ffga_pkg.sv =====
// ffga_pkg: shared widths, opcodes, sequencer states and unit result type
// for the first-fit gap allocator. No dependencies.
package ffga_pkg;

   localparam int GAP_W = 16;   // gap and request size width
   localparam int IDX_W = 12;   // entry and slot index width
   localparam int LIM_W = 13;   // signed search limit width

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_ALLOC = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SEARCH,
      ST_ASCEND,
      ST_LEAF,
      ST_UPDATE
   } state_type;

   // Result of the shared compare/subtract unit
   typedef struct packed {
      logic             ge;     // a >= b
      logic [GAP_W-1:0] diff;   // a - b
      logic [GAP_W-1:0] max;    // larger of a and b
   } alu_out_type;

endpackage

// ===== hdl/first_fit_gap_allocator.sv =====
// first_fit_gap_allocator: first-fit allocator over a max tree of gap sizes.
// A write refreshes the tree from its leaf up to the root; an allocate searches the tree
//   and, on a hit, refreshes it the same way; a miss is answered without a refresh.
//   An out-of-range write or negative limit is answered straight from idle, busy staying low.
// One transaction at a time; otherwise busy is high until its result strobe is registered.
// Reset: synchronous clearing sweep of all 2*2^ceil(log2(ENTRIES)) tree nodes (8192 by default).
// Depends on ffga_pkg, ffga_ram, ffga_seq.
module first_fit_gap_allocator #(
   parameter int ENTRIES = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_opcode,
   input  logic [ffga_pkg::IDX_W-1:0]        req_entry_index,
   input  logic [ffga_pkg::GAP_W-1:0]        req_gap_value,
   input  logic [ffga_pkg::GAP_W-1:0]        req_request_size,
   input  logic signed [ffga_pkg::LIM_W-1:0] req_search_limit,
   output logic                              rsp_strobe,
   output logic                              rsp_found,
   output logic [ffga_pkg::IDX_W-1:0]        rsp_slot_index,
   output logic [ffga_pkg::GAP_W-1:0]        rsp_remaining_gap
);
   import ffga_pkg::*;

   localparam int NODE_BITS = $clog2(ENTRIES) + 1;

   logic                 mem_wr_en;
   logic [NODE_BITS-1:0] mem_wr_addr;
   logic [GAP_W-1:0]     mem_wr_data;
   logic [NODE_BITS-1:0] mem_rd_addr;
   logic [GAP_W-1:0]     mem_rd_data;

   // Tree node storage, node 1 is the root
   ffga_ram #(
      .WIDTH (GAP_W),
      .DEPTH (2 ** NODE_BITS)
   ) u_tree (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   ffga_seq #(
      .ENTRIES (ENTRIES)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_entry_index   (req_entry_index),
      .req_gap_value     (req_gap_value),
      .req_request_size  (req_request_size),
      .req_search_limit  (req_search_limit),
      .rsp_strobe        (rsp_strobe),
      .rsp_found         (rsp_found),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_remaining_gap (rsp_remaining_gap),
      .mem_wr_en         (mem_wr_en),
      .mem_wr_addr       (mem_wr_addr),
      .mem_wr_data       (mem_wr_data),
      .mem_rd_addr       (mem_rd_addr),
      .mem_rd_data       (mem_rd_data)
   );

endmodule

// ===== hdl/ffga_ram.sv =====
// ffga_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module ffga_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ffga_alu.sv =====
// ffga_alu: shared compare/subtract unit; one subtract gives a >= b,
// a - b and max(a, b). Depends on ffga_pkg.
module ffga_alu (
   input  logic [ffga_pkg::GAP_W-1:0] a,
   input  logic [ffga_pkg::GAP_W-1:0] b,
   output ffga_pkg::alu_out_type      res
);
   import ffga_pkg::*;

   logic [GAP_W:0] diff_wide;

   // borrow out of the subtract is the compare result
   always_comb begin
      diff_wide = {1'b0, a} - {1'b0, b};
      res.ge    = ~diff_wide[GAP_W];
      res.diff  = diff_wide[GAP_W-1:0];
      res.max   = res.ge ? a : b;
   end

endmodule

// ===== hdl/ffga_seq.sv =====
// ffga_seq: sequencer that walks the max tree one node per cycle: clearing
// sweep, first-fit descent with backtracking, and leaf-to-root refresh.
// Depends on ffga_pkg and ffga_alu.
module ffga_seq #(
   parameter int ENTRIES = 4096
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   output logic                                       busy,
   input  logic                                       req_opcode,
   input  logic [ffga_pkg::IDX_W-1:0]                 req_entry_index,
   input  logic [ffga_pkg::GAP_W-1:0]                 req_gap_value,
   input  logic [ffga_pkg::GAP_W-1:0]                 req_request_size,
   input  logic signed [ffga_pkg::LIM_W-1:0]          req_search_limit,
   output logic                                       rsp_strobe,
   output logic                                       rsp_found,
   output logic [ffga_pkg::IDX_W-1:0]                 rsp_slot_index,
   output logic [ffga_pkg::GAP_W-1:0]                 rsp_remaining_gap,
   output logic                                       mem_wr_en,
   output logic [$clog2(ENTRIES):0]                   mem_wr_addr,
   output logic [ffga_pkg::GAP_W-1:0]                 mem_wr_data,
   output logic [$clog2(ENTRIES):0]                   mem_rd_addr,
   input  logic [ffga_pkg::GAP_W-1:0]                 mem_rd_data
);
   import ffga_pkg::*;

   localparam int LEAF_BITS = $clog2(ENTRIES);
   localparam int NODE_BITS = LEAF_BITS + 1;
   localparam int LVL_BITS  = $clog2(LEAF_BITS + 1);
   localparam int LEAVES    = 2 ** LEAF_BITS;

   localparam logic [NODE_BITS-1:0] ROOT      = NODE_BITS'(1);
   localparam logic [NODE_BITS-1:0] LEAF_BASE = NODE_BITS'(LEAVES);
   localparam logic [NODE_BITS-1:0] LAST_NODE = '1;
   localparam logic [LVL_BITS-1:0]  LEAF_LVL  = LVL_BITS'(LEAF_BITS);
   localparam logic [LEAF_BITS-1:0] LIM_MAX   = LEAF_BITS'(ENTRIES - 1);

   state_type               state_ff, state_in;
   logic [NODE_BITS-1:0]    node_ff, node_in;
   logic [LVL_BITS-1:0]     lvl_ff, lvl_in;
   logic [NODE_BITS-1:0]    clr_ff, clr_in;
   logic [GAP_W-1:0]        cur_ff, cur_in;
   logic [GAP_W-1:0]        need_ff, need_in;
   logic [LEAF_BITS-1:0]    lim_ff, lim_in;
   logic                    found_ff, found_in;
   logic [LEAF_BITS-1:0]    slot_ff, slot_in;
   logic [GAP_W-1:0]        rem_ff, rem_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0]        rsp_slot_ff, rsp_slot_in;
   logic [GAP_W-1:0]        rsp_gap_ff, rsp_gap_in;

   alu_out_type             alu_res;
   logic [GAP_W-1:0]        alu_b;
   logic [NODE_BITS-1:0]    node_shifted;
   logic [LEAF_BITS-1:0]    node_lo;
   logic                    in_range;
   logic [NODE_BITS-1:0]    parent;
   logic [IDX_W-1:0]        lim_mag;

   // Shared unit: rd_data against the request (search) or the carried max (update)
   assign alu_b = (state_ff == ST_UPDATE) ? cur_ff : need_ff;

   ffga_alu u_alu (
      .a   (mem_rd_data),
      .b   (alu_b),
      .res (alu_res)
   );

   // Lowest leaf index covered by the current node
   always_comb begin
      node_shifted = node_ff << (LEAF_LVL - lvl_ff);
      node_lo      = node_shifted[LEAF_BITS-1:0];
      in_range     = (node_lo <= lim_ff);
      parent       = node_ff >> 1;
      lim_mag      = req_search_limit[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff      <= node_in;
      lvl_ff       <= lvl_in;
      cur_ff       <= cur_in;
      need_ff      <= need_in;
      lim_ff       <= lim_in;
      found_ff     <= found_in;
      slot_ff      <= slot_in;
      rem_ff       <= rem_in;
      rsp_found_ff <= rsp_found_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_gap_ff   <= rsp_gap_in;
   end

   // Next state, datapath and memory control
   always_comb begin
      state_in      = state_ff;
      node_in       = node_ff;
      lvl_in        = lvl_ff;
      clr_in        = clr_ff;
      cur_in        = cur_ff;
      need_in       = need_ff;
      lim_in        = lim_ff;
      found_in      = found_ff;
      slot_in       = slot_ff;
      rem_in        = rem_ff;
      rsp_strobe_in = 1'b0;
      rsp_found_in  = rsp_found_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_gap_in    = rsp_gap_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = node_ff;
      mem_wr_data   = cur_ff;
      mem_rd_addr   = node_ff;

      unique case (state_ff)
         // zero every tree node, one per cycle
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
            clr_in      = clr_ff + NODE_BITS'(1);
            if (clr_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (start) begin
               priority if (req_opcode == OP_WRITE) begin
                  if (32'(req_entry_index) < ENTRIES) begin
                     node_in  = LEAF_BASE | NODE_BITS'(req_entry_index);
                     cur_in   = req_gap_value;
                     found_in = 1'b0;
                     slot_in  = '0;
                     rem_in   = '0;
                     state_in = ST_LEAF;
                  end else begin
                     // out-of-range write: table untouched
                     rsp_strobe_in = 1'b1;
                     rsp_found_in  = 1'b0;
                     rsp_slot_in   = '0;
                     rsp_gap_in    = '0;
                  end
               end else if (req_search_limit[LIM_W-1]) begin
                  // negative limit: empty range
                  rsp_strobe_in = 1'b1;
                  rsp_found_in  = 1'b0;
                  rsp_slot_in   = '0;
                  rsp_gap_in    = '0;
               end else begin
                  node_in     = ROOT;
                  lvl_in      = '0;
                  need_in     = req_request_size;
                  lim_in      = (32'(lim_mag) >= ENTRIES) ? LIM_MAX
                                                           : LEAF_BITS'(lim_mag);
                  mem_rd_addr = ROOT;
                  state_in    = ST_SEARCH;
               end
            end
         end

         // in ST_SEARCH rd_data holds tree[node]; take a fitting leaf, descend, step right, back up, or miss
         ST_SEARCH, ST_ASCEND: begin
            priority if (state_ff == ST_SEARCH && in_range && alu_res.ge
                         && lvl_ff == LEAF_LVL) begin
               found_in = 1'b1;
               slot_in  = node_lo;
               rem_in   = alu_res.diff;
               cur_in   = alu_res.diff;
               state_in = ST_LEAF;
            end else if (state_ff == ST_SEARCH && in_range && alu_res.ge) begin
               node_in     = {node_ff[NODE_BITS-2:0], 1'b0};
               lvl_in      = lvl_ff + LVL_BITS'(1);
               mem_rd_addr = {node_ff[NODE_BITS-2:0], 1'b0};
               state_in    = ST_SEARCH;
            end else if (!node_ff[0]) begin
               // left child exhausted: try its right sibling
               node_in     = node_ff + NODE_BITS'(1);
               mem_rd_addr = node_ff + NODE_BITS'(1);
               state_in    = ST_SEARCH;
            end else if (node_ff == ROOT) begin
               // whole tree exhausted: miss
               rsp_strobe_in = 1'b1;
               rsp_found_in  = 1'b0;
               rsp_slot_in   = '0;
               rsp_gap_in    = '0;
               state_in      = ST_IDLE;
            end else begin
               node_in  = parent;
               lvl_in   = lvl_ff - LVL_BITS'(1);
               state_in = ST_ASCEND;
            end
         end

         // write the leaf, fetch its sibling
         ST_LEAF: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = node_ff;
            mem_wr_data = cur_ff;
            mem_rd_addr = node_ff ^ NODE_BITS'(1);
            state_in    = ST_UPDATE;
         end

         // parent = max(carried value, sibling); fetch the parent's sibling
         ST_UPDATE: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = parent;
            mem_wr_data = alu_res.max;
            mem_rd_addr = parent ^ NODE_BITS'(1);
            node_in     = parent;
            cur_in      = alu_res.max;
            if (parent == ROOT) begin
               rsp_strobe_in = 1'b1;
               rsp_found_in  = found_ff;
               rsp_slot_in   = IDX_W'(slot_ff);
               rsp_gap_in    = rem_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_slot_index    = rsp_slot_ff;
   assign rsp_remaining_gap = rsp_gap_ff;

endmodule

// ===== bench/ffga_checker.sv =====
// ffga_checker: watches the command and result channels of the first-fit gap
// allocator, predicts each result from its own gap table and compares.
// Depends on ffga_pkg.
module ffga_checker #(
   parameter int ENTRIES = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic                              req_opcode,
   input  logic [ffga_pkg::IDX_W-1:0]        req_entry_index,
   input  logic [ffga_pkg::GAP_W-1:0]        req_gap_value,
   input  logic [ffga_pkg::GAP_W-1:0]        req_request_size,
   input  logic signed [ffga_pkg::LIM_W-1:0] req_search_limit,
   input  logic                              rsp_strobe,
   input  logic                              rsp_found,
   input  logic [ffga_pkg::IDX_W-1:0]        rsp_slot_index,
   input  logic [ffga_pkg::GAP_W-1:0]        rsp_remaining_gap,
   output int                                fail_count,
   output int                                pending
);

   timeunit 1ns;
   timeprecision 1ps;

   import ffga_pkg::*;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] slot;
      logic [GAP_W-1:0] left;
   } grant_type;

   // Flat copy of the leaf gaps; the search is a plain linear scan
   logic [GAP_W-1:0] gap_table [ENTRIES];
   grant_type        expected_grants [$];
   int               mismatches = 0;

   // Apply one transaction to the gap table and return the grant it produces
   function automatic grant_type store_or_allocate(input logic             op,
                                                   input logic [IDX_W-1:0] idx,
                                                   input logic [GAP_W-1:0] gval,
                                                   input logic [GAP_W-1:0] need,
                                                   input logic [LIM_W-1:0] lim);
      grant_type g;
      int        top;
      g = '0;
      if (op == OP_WRITE) begin
         if (int'(idx) < ENTRIES)
            gap_table[idx] = gval;
         return g;
      end
      // sign bit set: empty search range
      if (lim[LIM_W-1])
         return g;
      top = int'(lim);
      if (top > ENTRIES - 1)
         top = ENTRIES - 1;
      for (int i = 0; i <= top; i++) begin
         if (gap_table[i] >= need) begin
            gap_table[i] = gap_table[i] - need;
            g.found = 1'b1;
            g.slot  = IDX_W'(i);
            g.left  = gap_table[i];
            return g;
         end
      end
      return g;
   endfunction

   // Compare results first, then record a newly accepted transaction
   always @(posedge clock) begin : watch
      grant_type want;
      grant_type fresh;
      if (reset) begin
         foreach (gap_table[i])
            gap_table[i] = '0;
         expected_grants.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_grants.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result with nothing outstanding: ",
                           "found=%0b slot=%0d gap=%0d",
                           $realtime, rsp_found, rsp_slot_index, rsp_remaining_gap);
            end else begin
               want = expected_grants.pop_front();
               if (rsp_found !== want.found || rsp_slot_index !== want.slot ||
                   rsp_remaining_gap !== want.left) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch exp found=%0b slot=%0d gap=%0d, ",
                              "got found=%0b slot=%0d gap=%0d",
                              $realtime, want.found, want.slot, want.left,
                              rsp_found, rsp_slot_index, rsp_remaining_gap);
               end
            end
         end
         if (start && !busy) begin
            fresh = store_or_allocate(req_opcode, req_entry_index,
                                      req_gap_value, req_request_size,
                                      req_search_limit);
            expected_grants = {expected_grants, fresh};
         end
      end
      fail_count <= mismatches;
      pending    <= expected_grants.size();
   end

endmodule

// ===== bench/first_fit_gap_allocator_tb.sv =====
// first_fit_gap_allocator_tb: drives directed and random write/allocate
// transactions in bursts and gives the verdict from ffga_checker's count.
// Depends on ffga_pkg, ffga_checker and the first_fit_gap_allocator RTL.
module first_fit_gap_allocator_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import ffga_pkg::*;

   localparam int ENTRIES     = 4096;
   localparam int RANDOM_TXNS = 650;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_WAIT  = 120;

   logic                     clock             = 1'b0;
   logic                     reset             = 1'b1;
   logic                     start             = 1'b0;
   logic                     busy;
   logic                     req_opcode        = OP_WRITE;
   logic [IDX_W-1:0]         req_entry_index   = '0;
   logic [GAP_W-1:0]         req_gap_value     = '0;
   logic [GAP_W-1:0]         req_request_size  = '0;
   logic signed [LIM_W-1:0]  req_search_limit  = '0;
   logic                     rsp_strobe;
   logic                     rsp_found;
   logic [IDX_W-1:0]         rsp_slot_index;
   logic [GAP_W-1:0]         rsp_remaining_gap;
   int                       fail_count;
   int                       pending;
   int                       cycles = 0;
   int                       burst_left = 0;
   bit                       no_idle = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   first_fit_gap_allocator #(.ENTRIES(ENTRIES)) u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_entry_index   (req_entry_index),
      .req_gap_value     (req_gap_value),
      .req_request_size  (req_request_size),
      .req_search_limit  (req_search_limit),
      .rsp_strobe        (rsp_strobe),
      .rsp_found         (rsp_found),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_remaining_gap (rsp_remaining_gap)
   );

   ffga_checker #(.ENTRIES(ENTRIES)) u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_entry_index   (req_entry_index),
      .req_gap_value     (req_gap_value),
      .req_request_size  (req_request_size),
      .req_search_limit  (req_search_limit),
      .rsp_strobe        (rsp_strobe),
      .rsp_found         (rsp_found),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_remaining_gap (rsp_remaining_gap),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   // Watchdog; the clearing sweep after reset is well inside this
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Present one transaction with start high, then wait on clock edges until busy is low
   task automatic issue(input logic             op,
                        input logic [IDX_W-1:0] idx,
                        input logic [GAP_W-1:0] gval,
                        input logic [GAP_W-1:0] need,
                        input logic [LIM_W-1:0] lim);
      req_opcode       <= op;
      req_entry_index  <= idx;
      req_gap_value    <= gval;
      req_request_size <= need;
      req_search_limit <= lim;
      start            <= 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   // Bursts of back-to-back transactions separated by random idle gaps
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 16);
         case ($urandom_range(0, 3))
            0:       gap = 0;
            1:       gap = $urandom_range(1, 3);
            2:       gap = $urandom_range(4, 12);
            default: gap = $urandom_range(13, 40);
         endcase
         if (no_idle)
            gap = 0;
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic issue_random();
      logic             op;
      logic [IDX_W-1:0] idx;
      logic [GAP_W-1:0] gval;
      logic [GAP_W-1:0] need;
      logic [LIM_W-1:0] lim;
      int               pick;
      op   = ($urandom_range(0, 99) < 45) ? OP_WRITE : OP_ALLOC;
      // clustered indexes so allocations find populated subtrees
      pick = $urandom_range(0, 99);
      if (pick < 60)
         idx = IDX_W'($urandom_range(0, 127));
      else if (pick < 85)
         idx = IDX_W'($urandom_range(0, ENTRIES - 1));
      else
         idx = IDX_W'(ENTRIES - 1 - $urandom_range(0, 63));
      pick = $urandom_range(0, 99);
      if (pick < 50)
         gval = GAP_W'($urandom_range(0, 300));
      else if (pick < 80)
         gval = GAP_W'($urandom);
      else if (pick < 90)
         gval = '1;
      else
         gval = '0;
      pick = $urandom_range(0, 99);
      if (pick < 50)
         need = GAP_W'($urandom_range(0, 200));
      else if (pick < 75)
         need = GAP_W'($urandom);
      else if (pick < 85)
         need = '0;
      else
         need = GAP_W'($urandom_range(65000, 65535));
      pick = $urandom_range(0, 99);
      if (pick < 10)
         lim = LIM_W'($urandom_range(4096, 8191));    // negative range
      else if (pick < 15)
         lim = '1;
      else if (pick < 45)
         lim = LIM_W'(ENTRIES - 1);
      else if (pick < 75)
         lim = LIM_W'($urandom_range(0, 160));
      else
         lim = LIM_W'($urandom_range(0, ENTRIES - 1));
      issue(op, idx, gval, need, lim);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, exact fits, limits on both sides, zero request
      issue(OP_WRITE, 12'd0,    16'hFFFF, '0, '0);
      issue(OP_WRITE, 12'd4095, 16'hFFFF, '0, '0);
      issue(OP_WRITE, 12'd5,    16'd100,  '0, '0);
      issue(OP_ALLOC, '0, '0, 16'd0,    13'sd4095);   // zero request: index 0
      issue(OP_ALLOC, '0, '0, 16'hFFFF, 13'sd4095);   // empties index 0
      issue(OP_ALLOC, '0, '0, 16'hFFFF, 13'sd4095);   // rightmost leaf
      issue(OP_ALLOC, '0, '0, 16'd1,    -13'sd1);     // empty range
      issue(OP_ALLOC, '0, '0, 16'd1,    13'h1000);    // most negative limit
      issue(OP_ALLOC, '0, '0, 16'd101,  13'sd4095);   // miss on size
      issue(OP_ALLOC, '0, '0, 16'd100,  13'sd4);      // fit lies past limit
      issue(OP_ALLOC, '0, '0, 16'd100,  13'sd5);      // exact fit at the limit
      issue(OP_WRITE, 12'hAAA, 16'h5555, '0, '0);
      issue(OP_WRITE, 12'h555, 16'hAAAA, '0, '0);
      issue(OP_ALLOC, '0, '0, 16'hAAAA, 13'sd4095);
      issue(OP_ALLOC, '0, '0, 16'h5555, 13'sd2730);
      issue(OP_WRITE, 12'd0, 16'd0, '0, '0);
      issue(OP_ALLOC, '0, '0, 16'd0, 13'sd0);
      issue(OP_ALLOC, '0, '0, 16'd0, -13'sd1);
      issue(OP_WRITE, 12'hFFF, 16'd7, 16'hFFFF, 13'h0FFF);
      issue(OP_ALLOC, 12'hFFF, 16'hFFFF, 16'd7, 13'h0FFF);

      // Random traffic with one drain pause and one stretch without idling
      for (int n = 0; n < RANDOM_TXNS; n++) begin
         pace();
         if (n == 300) begin
            start <= 1'b0;
            @(posedge clock);
            while (pending != 0)
               @(posedge clock);
         end
         no_idle = (n >= 420 && n < 500);
         issue_random();
      end
      start <= 1'b0;

      // Drain, then allow the slowest transaction time to misbehave
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/ffga_pkg.sv
hdl/ffga_ram.sv
hdl/ffga_alu.sv
hdl/ffga_seq.sv
hdl/first_fit_gap_allocator.sv
bench/ffga_checker.sv
bench/first_fit_gap_allocator_tb.sv
